// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bitmap page allocator: command and
// status codes, and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // field widths of the item
  localparam int unsigned IDX_W = 12;
  localparam int unsigned PG_W  = 13;

  // map word geometry: one byte of occupancy bits per memory word
  localparam int unsigned BYTE_PAGES = 8;
  localparam int unsigned BYTE_SHIFT = 3;
  localparam logic [BYTE_PAGES-1:0] FULL_BYTE = 8'hFF;

  // page count register value after reset
  localparam logic [PG_W-1:0] PAGE_COUNT_RST = 13'd4096;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_SET   = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_RUN    = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FREE_FREE = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;        // capture the input item
    logic    clr_step;    // clear one map word after reset
    logic    init_scan;   // start first-fit search at page 0
    logic    init_range;  // set up the page range of free, query or set
    logic    scan_eval;   // evaluate one map word of the search
    logic    chk_eval;    // step the free-run check
    logic    qry_eval;    // capture the queried bit
    logic    wr_en;       // write back one merged map word
    logic    code_we;     // update the status code
    status_e code;
    logic    load_out;    // move the result into the output register
  } bpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    command_e cmd;
    logic     len_zero;
    logic     len_gt_n;
    logic     free_oob;
    logic     idx_oob;
    logic     found;
    logic     chk_fail;
    logic     ptr_last;
    logic     clr_done;
    logic     out_free;
  } bpa_stat_t;

endpackage

// ===== design/bitmap_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit page allocator over a one-bit-per-page occupancy map.
// ----------------------------------------------------------------------------
// The map is held as one byte-wide memory word per eight pages and is
// handled one word per step, each step being a read followed by an evaluate
// or write cycle. An allocate searches word by word and stops at the first
// fitting run, then marks that run word by word; a free checks each map word
// of its run and then writes each back; a query or a set handles the single
// word of its page; a rejected command goes straight to the result. One result
// register holds the answer, so the next item is taken while a result waits
// on out_stall_i. After reset the map is swept to all free while in_stall_o
// stays high; the page count register can be written at any time the block
// is idle and cfg_ready_o is always high.
module bitmap_page_allocator_core #(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: page count
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bpa_pkg::PG_W-1:0]   cfg_page_count_i,
  // command items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [bpa_pkg::IDX_W-1:0]  page_index_i,
  input  logic [bpa_pkg::PG_W-1:0]   run_length_i,
  input  logic                       new_status_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bpa_pkg::IDX_W-1:0]  result_index_o,
  output logic                       in_use_o,
  output logic [1:0]                 status_code_o
);
  import bpa_pkg::*;

  bpa_cmd_t        ctl;
  bpa_stat_t       stat;
  logic [PG_W-1:0] page_count_q;

  // page count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= PAGE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      page_count_q <= cfg_page_count_i;
    end
  end

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  bpa_dpath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .page_count_i   (page_count_q),
    .command_i      (command_i),
    .page_index_i   (page_index_i),
    .run_length_i   (run_length_i),
    .new_status_i   (new_status_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_index_o (result_index_o),
    .in_use_o       (in_use_o),
    .status_code_o  (status_code_o)
  );

endmodule

// ===== design/bpa_dpath.sv =====
// ----------------------------------------------------------------------------
// bpa_dpath
// Datapath of the page allocator: byte-wide occupancy memory, search and
// check logic over one map word per step, and the result register.
// ----------------------------------------------------------------------------
module bpa_dpath #(
  parameter int unsigned MAX_PAGES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpa_pkg::bpa_cmd_t            ctl_i,
  output bpa_pkg::bpa_stat_t           stat_o,
  input  logic [bpa_pkg::PG_W-1:0]     page_count_i,
  input  logic [1:0]                   command_i,
  input  logic [bpa_pkg::IDX_W-1:0]    page_index_i,
  input  logic [bpa_pkg::PG_W-1:0]     run_length_i,
  input  logic                         new_status_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bpa_pkg::IDX_W-1:0]    result_index_o,
  output logic                         in_use_o,
  output logic [1:0]                   status_code_o
);
  import bpa_pkg::*;

  localparam int unsigned DEPTH = (MAX_PAGES + BYTE_PAGES - 1) / BYTE_PAGES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NCAP  = (MAX_PAGES > (2**PG_W - 1)) ? (2**PG_W - 1) : MAX_PAGES;
  localparam int unsigned BW    = PG_W - BYTE_SHIFT;

  // occupancy memory, bit j of word b is page 8*b+j
  logic [BYTE_PAGES-1:0] map_mem [2**AW];
  logic [BYTE_PAGES-1:0] rdata_q;
  logic [AW-1:0]         clr_cnt_q;

  // captured item and working registers
  command_e         cmd_q;
  logic [IDX_W-1:0] idx_q;
  logic [PG_W-1:0]  len_q;
  logic             stat_q;
  logic [PG_W-1:0]  n_q;
  logic [PG_W-1:0]  s_q, e_q;
  logic [BW-1:0]    ptr_q, last_q;
  logic [PG_W-1:0]  run_q;
  logic [IDX_W-1:0] res_idx_q;
  logic             use_q;
  status_e          code_q;

  // output register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_use_q;
  status_e          out_code_q;

  logic [PG_W-1:0]       n_sel;
  logic [PG_W-1:0]       idx_ext;
  logic [PG_W-1:0]       e_rng;
  logic [BYTE_PAGES-1:0] mask;
  logic [2:0]            mask_lo, mask_hi;
  logic [BYTE_PAGES-1:0] wdata;
  logic                  set_mode;

  // search signals
  logic [3:0]       lr;
  logic [PG_W:0]    tot;
  logic [PG_W-1:0]  pg;
  logic             pg_free;
  logic             hit_found;
  logic [2:0]       hit_j;
  logic [PG_W-1:0]  hit_pg;
  logic [PG_W-1:0]  hit_start;
  logic [PG_W-1:0]  run_nxt;

  assign n_sel   = (page_count_i > PG_W'(NCAP)) ? PG_W'(NCAP) : page_count_i;
  assign idx_ext = PG_W'(idx_q);
  assign e_rng   = (cmd_q == CMD_FREE) ? PG_W'(idx_ext + len_q - PG_W'(1)) : idx_ext;

  // mask of the pages of the current word that lie in [s, e]
  assign mask_lo = (ptr_q == s_q[PG_W-1:BYTE_SHIFT]) ? s_q[2:0] : 3'd0;
  assign mask_hi = (ptr_q == e_q[PG_W-1:BYTE_SHIFT]) ? e_q[2:0] : 3'd7;
  assign mask    = (FULL_BYTE << mask_lo) & (FULL_BYTE >> (3'd7 - mask_hi));

  assign set_mode = (cmd_q == CMD_ALLOC) || ((cmd_q == CMD_SET) && stat_q);
  assign wdata    = set_mode ? (rdata_q | mask) : (rdata_q & ~mask);

  // first-fit search over the eight pages of one word
  always_comb begin
    lr        = '0;
    tot       = '0;
    pg        = '0;
    pg_free   = 1'b0;
    hit_found = 1'b0;
    hit_j     = '0;
    for (int j = 0; j < BYTE_PAGES; j++) begin
      pg      = {ptr_q, 3'(j)};
      pg_free = !rdata_q[j] && (pg < n_q);
      lr      = pg_free ? lr + 4'd1 : 4'd0;
      tot     = (lr == 4'(j + 1)) ? ({1'b0, run_q} + (PG_W+1)'(j + 1)) : (PG_W+1)'(lr);
      if (pg_free && (tot >= {1'b0, len_q}) && !hit_found) begin
        hit_found = 1'b1;
        hit_j     = 3'(j);
      end
    end
  end

  assign hit_pg    = {ptr_q, hit_j};
  assign hit_start = PG_W'(hit_pg + PG_W'(1) - len_q);
  assign run_nxt   = PG_W'(tot);

  // status to the controller
  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.len_zero = (len_q == '0);
    stat_o.len_gt_n = (len_q > n_q);
    stat_o.free_oob = ({1'b0, idx_ext} + {1'b0, len_q}) > {1'b0, n_q};
    stat_o.idx_oob  = (idx_ext >= n_q);
    stat_o.found    = hit_found;
    stat_o.chk_fail = ((rdata_q & mask) != mask);
    stat_o.ptr_last = (ptr_q == last_q);
    stat_o.clr_done = &clr_cnt_q;
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  // map memory: clearing sweep, write-back and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_step) begin
      map_mem[clr_cnt_q] <= '0;
    end else if (ctl_i.wr_en) begin
      map_mem[AW'(ptr_q)] <= wdata;
    end
    rdata_q <= map_mem[AW'(ptr_q)];
  end

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // item capture and working registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q     <= command_e'(command_i);
      idx_q     <= page_index_i;
      len_q     <= run_length_i;
      stat_q    <= new_status_i;
      n_q       <= n_sel;
      res_idx_q <= page_index_i;
      use_q     <= 1'b0;
      code_q    <= ST_OK;
    end else begin
      if (ctl_i.code_we) begin
        code_q <= ctl_i.code;
      end
      if (ctl_i.qry_eval) begin
        use_q <= rdata_q[idx_q[2:0]];
      end
    end

    priority if (ctl_i.init_scan) begin
      ptr_q  <= '0;
      last_q <= BW'((n_q - PG_W'(1)) >> BYTE_SHIFT);
      run_q  <= '0;
    end else if (ctl_i.init_range) begin
      s_q    <= idx_ext;
      e_q    <= e_rng;
      ptr_q  <= idx_ext[PG_W-1:BYTE_SHIFT];
      last_q <= e_rng[PG_W-1:BYTE_SHIFT];
    end else if (ctl_i.scan_eval) begin
      if (hit_found) begin
        s_q       <= hit_start;
        e_q       <= hit_pg;
        ptr_q     <= hit_start[PG_W-1:BYTE_SHIFT];
        last_q    <= hit_pg[PG_W-1:BYTE_SHIFT];
        res_idx_q <= hit_start[IDX_W-1:0];
      end else begin
        run_q <= run_nxt;
        ptr_q <= ptr_q + BW'(1);
      end
    end else if (ctl_i.chk_eval) begin
      ptr_q <= (ptr_q == last_q) ? s_q[PG_W-1:BYTE_SHIFT] : ptr_q + BW'(1);
    end else if (ctl_i.wr_en) begin
      ptr_q <= ptr_q + BW'(1);
    end else begin
      ptr_q <= ptr_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_idx_q  <= res_idx_q;
      out_use_q  <= use_q;
      out_code_q <= code_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_index_o = out_idx_q;
  assign in_use_o       = out_use_q;
  assign status_code_o  = out_code_q;

`ifndef SYNTHESIS
  // a new result never overwrites one that is still waiting
  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  // write-back stays below the page count
  a_wr_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr_en |-> ({ptr_q, 3'b000} < n_q))
    else $error("map write beyond page count");

  // a found run ends inside the map
  a_hit_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.scan_eval && hit_found) |-> (hit_pg < n_q))
    else $error("allocated run passes page count");

  // a search step without a hit leaves the running count short of the length
  a_run_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.scan_eval && !hit_found) |=> (run_q < len_q))
    else $error("free run count reached length without a hit");
`endif

endmodule

// ===== design/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller of the page allocator: sequences the clearing sweep, command
// decode, word-by-word search or check, write-back and result hand-off.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bpa_pkg::bpa_stat_t  stat_i,
  output bpa_pkg::bpa_cmd_t   ctl_o
);
  import bpa_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_DECODE  = 12'b0000_0000_0100,
    S_SCAN_RD = 12'b0000_0000_1000,
    S_SCAN_EV = 12'b0000_0001_0000,
    S_CHK_RD  = 12'b0000_0010_0000,
    S_CHK_EV  = 12'b0000_0100_0000,
    S_QRY_RD  = 12'b0000_1000_0000,
    S_QRY_EV  = 12'b0001_0000_0000,
    S_WR_RD   = 12'b0010_0000_0000,
    S_WR_WR   = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.code = ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        ctl_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_ALLOC: begin
            priority if (stat_i.len_zero) begin
              ctl_o.code_we = 1'b1;
              ctl_o.code    = ST_RANGE;
              state_d       = S_DONE;
            end else if (stat_i.len_gt_n) begin
              ctl_o.code_we = 1'b1;
              ctl_o.code    = ST_NO_RUN;
              state_d       = S_DONE;
            end else begin
              ctl_o.init_scan = 1'b1;
              state_d         = S_SCAN_RD;
            end
          end
          CMD_FREE: begin
            if (stat_i.len_zero || stat_i.free_oob) begin
              ctl_o.code_we = 1'b1;
              ctl_o.code    = ST_RANGE;
              state_d       = S_DONE;
            end else begin
              ctl_o.init_range = 1'b1;
              state_d          = S_CHK_RD;
            end
          end
          CMD_QUERY: begin
            if (stat_i.idx_oob) begin
              ctl_o.code_we = 1'b1;
              ctl_o.code    = ST_RANGE;
              state_d       = S_DONE;
            end else begin
              ctl_o.init_range = 1'b1;
              state_d          = S_QRY_RD;
            end
          end
          CMD_SET: begin
            if (stat_i.idx_oob) begin
              ctl_o.code_we = 1'b1;
              ctl_o.code    = ST_RANGE;
              state_d       = S_DONE;
            end else begin
              ctl_o.init_range = 1'b1;
              state_d          = S_WR_RD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN_RD: state_d = S_SCAN_EV;
      S_SCAN_EV: begin
        ctl_o.scan_eval = 1'b1;
        priority if (stat_i.found) begin
          state_d = S_WR_RD;
        end else if (stat_i.ptr_last) begin
          ctl_o.code_we = 1'b1;
          ctl_o.code    = ST_NO_RUN;
          state_d       = S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_CHK_RD: state_d = S_CHK_EV;
      S_CHK_EV: begin
        priority if (stat_i.chk_fail) begin
          ctl_o.code_we = 1'b1;
          ctl_o.code    = ST_FREE_FREE;
          state_d       = S_DONE;
        end else if (stat_i.ptr_last) begin
          ctl_o.chk_eval = 1'b1;
          state_d        = S_WR_RD;
        end else begin
          ctl_o.chk_eval = 1'b1;
          state_d        = S_CHK_RD;
        end
      end
      S_QRY_RD: state_d = S_QRY_EV;
      S_QRY_EV: begin
        ctl_o.qry_eval = 1'b1;
        state_d        = S_DONE;
      end
      S_WR_RD: state_d = S_WR_WR;
      S_WR_WR: begin
        ctl_o.wr_en = 1'b1;
        state_d     = stat_i.ptr_last ? S_DONE : S_WR_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // state register, clearing sweep runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
